### src/pars_pkg.sv
// ----------------------------------------------------------------------------
// pars_pkg
// Shared types and codes for the packet admission and run state unit.
// ----------------------------------------------------------------------------
package pars_pkg;

   localparam int TypeWidth   = 24;
   localparam int StatusWidth = 2;
   localparam int PulseWidth  = 64;
   localparam int CountWidth  = 32;

   // packet type codes, version in the low byte
   localparam logic [TypeWidth-1:0] TypeRunStatus  = 24'h400300;
   localparam logic [TypeWidth-1:0] TypePixelMap   = 24'h400200;
   localparam logic [TypeWidth-1:0] TypeRunInfo    = 24'h400400;
   localparam logic [TypeWidth-1:0] TypeGeometry   = 24'h400A00;
   localparam logic [TypeWidth-1:0] TypeBeamInfo   = 24'h400B00;
   localparam logic [TypeWidth-1:0] TypeDevDesc    = 24'h800000;
   localparam logic [TypeWidth-1:0] TypeVarU32     = 24'h800100;
   localparam logic [TypeWidth-1:0] TypeVarDouble  = 24'h800200;
   localparam logic [TypeWidth-1:0] TypeBankEvent  = 24'h400000;
   localparam logic [TypeWidth-1:0] TypeBeamMon    = 24'h400100;

   // run status kinds
   localparam logic [StatusWidth-1:0] StatusNewRun = 2'd1;
   localparam logic [StatusWidth-1:0] StatusEndRun = 2'd2;

   // once-only bit positions
   localparam int OncePixelMap = 0;
   localparam int OnceRunInfo  = 1;
   localparam int OnceBeamInfo = 2;
   localparam int OnceGeometry = 3;

   localparam logic [CountWidth-1:0] CountMax = '1;

   typedef enum logic [1:0] {
      PHASE_WAITING = 2'd0,
      PHASE_HEADER  = 2'd1,
      PHASE_EVENTS  = 2'd2,
      PHASE_DONE    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CLS_RUN_STATUS,
      CLS_PIXEL_MAP,
      CLS_RUN_INFO,
      CLS_GEOMETRY,
      CLS_BEAM_INFO,
      CLS_SLOW,
      CLS_PULSE,
      CLS_OTHER
   } class_type;

   typedef struct packed {
      logic                  admitted;
      logic                  phase_error;
      phase_type             run_phase;
      logic [CountWidth-1:0] pulses_seen;
      logic [CountWidth-1:0] skip_total;
   } result_type;

endpackage

### src/pars_decode.sv
// ----------------------------------------------------------------------------
// pars_decode
// Sort a packet type code into its admission class.
// ----------------------------------------------------------------------------
module pars_decode
   import pars_pkg::*;
(
   input  logic [TypeWidth-1:0] packet_type,
   output class_type            pkt_class
);

   always_comb begin
      unique case (packet_type)
         TypeRunStatus: pkt_class = CLS_RUN_STATUS;
         TypePixelMap:  pkt_class = CLS_PIXEL_MAP;
         TypeRunInfo:   pkt_class = CLS_RUN_INFO;
         TypeGeometry:  pkt_class = CLS_GEOMETRY;
         TypeBeamInfo:  pkt_class = CLS_BEAM_INFO;
         TypeDevDesc, TypeVarU32, TypeVarDouble: pkt_class = CLS_SLOW;
         TypeBankEvent, TypeBeamMon:             pkt_class = CLS_PULSE;
         default:       pkt_class = CLS_OTHER;
      endcase
   end

endmodule

### src/pars_core.sv
// ----------------------------------------------------------------------------
// pars_core
// Run state registers and the admission decision for one packet.
// ----------------------------------------------------------------------------
module pars_core
   import pars_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  class_type              pkt_class,
   input  logic [StatusWidth-1:0] run_status,
   input  logic [PulseWidth-1:0]  pulse_id,
   input  logic                   count_skips,
   output result_type             result
);

   phase_type             phase_ff, phase_in;
   logic [3:0]            once_ff, once_in;
   logic [CountWidth-1:0] skip_cnt_ff, skip_cnt_in;
   logic [CountWidth-1:0] pulse_cnt_ff, pulse_cnt_in;
   logic [PulseWidth-1:0] last_pulse_ff, last_pulse_in;

   logic adm;
   logic err;
   logic hdr_or_ev;

   assign hdr_or_ev = (phase_ff == PHASE_HEADER) || (phase_ff == PHASE_EVENTS);

   always_comb begin
      phase_in      = phase_ff;
      once_in       = once_ff;
      pulse_cnt_in  = pulse_cnt_ff;
      last_pulse_in = last_pulse_ff;
      skip_cnt_in   = skip_cnt_ff;
      adm           = 1'b0;
      err           = 1'b0;
      unique case (pkt_class)
         CLS_RUN_STATUS: begin
            adm = 1'b1;
            if (run_status == StatusNewRun) begin
               if (phase_ff == PHASE_WAITING) phase_in = PHASE_HEADER;
            end else if (run_status == StatusEndRun) begin
               if (phase_ff == PHASE_EVENTS) phase_in = PHASE_DONE;
               else err = 1'b1;
            end
         end
         CLS_PIXEL_MAP: begin
            adm = hdr_or_ev && !once_ff[OncePixelMap];
            if (adm) begin
               once_in[OncePixelMap] = 1'b1;
               phase_in              = PHASE_EVENTS;
            end
         end
         CLS_RUN_INFO: begin
            adm = hdr_or_ev && !once_ff[OnceRunInfo];
            if (adm) once_in[OnceRunInfo] = 1'b1;
         end
         CLS_GEOMETRY: begin
            adm = hdr_or_ev && !once_ff[OnceGeometry];
            if (adm) once_in[OnceGeometry] = 1'b1;
         end
         CLS_BEAM_INFO: begin
            adm = hdr_or_ev && !once_ff[OnceBeamInfo];
            if (adm) once_in[OnceBeamInfo] = 1'b1;
         end
         CLS_SLOW: adm = hdr_or_ev;
         CLS_PULSE: begin
            adm = (phase_ff == PHASE_EVENTS);
            // a new pulse, or the very first one
            if (adm && (pulse_id != last_pulse_ff || pulse_cnt_ff == '0)) begin
               last_pulse_in = pulse_id;
               if (pulse_cnt_ff != CountMax) pulse_cnt_in = pulse_cnt_ff + 1'b1;
            end
         end
         CLS_OTHER: adm = 1'b0;
         default:   adm = 1'b0;
      endcase
      if (!adm && count_skips && skip_cnt_ff != CountMax) begin
         skip_cnt_in = skip_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_WAITING;
         once_ff       <= '0;
         skip_cnt_ff   <= '0;
         pulse_cnt_ff  <= '0;
         last_pulse_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         once_ff       <= once_in;
         skip_cnt_ff   <= skip_cnt_in;
         pulse_cnt_ff  <= pulse_cnt_in;
         last_pulse_ff <= last_pulse_in;
      end
   end

   assign result.admitted    = adm;
   assign result.phase_error = err;
   assign result.run_phase   = phase_in;
   assign result.pulses_seen = pulse_cnt_in;
   assign result.skip_total  = skip_cnt_in;

endmodule

### src/packet_admission_run_state_unit.sv
// ----------------------------------------------------------------------------
// packet_admission_run_state_unit
// Admission decision and run phase tracking for a stream of packet headers.
// ----------------------------------------------------------------------------
// Use:
//   req_*  carries one packet header per transfer: type code and run status
//          kind in tuser, pulse id in tdata.
//   rsp_*  carries one result per header: admitted, skipped and phase error
//          flags in tuser, run phase and the two saturating counters in tdata.
//   csr_*  writes the count_skips enable; write it only while no header is
//          in flight.
// A req transfer loads the header into the input register; once the result
// register is free or draining, the decision moves into the result register,
// which drives the rsp transfer. Throughput is one header per cycle while
// rsp_tready stays high; the decision is a type decode, a 64-bit pulse id
// compare and two 32-bit increments, all inside one register stage. When the
// receiver stalls, the result register holds its transfer and the input
// register still takes one more header; after that req_tready drops until
// rsp_tready returns.
// Reset clears the phase to waiting, the once-only bits, both counters, the
// last pulse id, the skip enable and both valid flags.
// ----------------------------------------------------------------------------
module packet_admission_run_state_unit
   import pars_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] pulse_id
   input  logic [25:0] req_tuser,   // [23:0] packet_type, [25:24] run_status
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [1:0] run_phase, [33:2] pulses_seen,
                                    // [65:34] skip_total, [71:66] zero
   output logic [2:0]  rsp_tuser,   // [0] admitted, [1] skipped, [2] phase_error
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                   count_skips_ff;

   logic                   in_valid_ff, in_valid_in;
   logic [TypeWidth-1:0]   in_type_ff;
   logic [StatusWidth-1:0] in_status_ff;
   logic [PulseWidth-1:0]  in_pid_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff;

   logic                   req_take;
   logic                   step;
   class_type              pkt_class;
   result_type             result;

   // advance the held header when the result register is free or draining
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      priority if (req_take) in_valid_in = 1'b1;
      else if (step)         in_valid_in = 1'b0;
      else                   in_valid_in = in_valid_ff;
   end

   always_comb begin
      priority if (step)   rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_skips_ff <= 1'b0;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) count_skips_ff <= csr_wr_data;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff   <= req_tuser[TypeWidth-1:0];
         in_status_ff <= req_tuser[TypeWidth+StatusWidth-1:TypeWidth];
         in_pid_ff    <= req_tdata;
      end
      if (step) rsp_ff <= result;
   end

   pars_decode u_decode (
      .packet_type (in_type_ff),
      .pkt_class   (pkt_class)
   );

   pars_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .pkt_class   (pkt_class),
      .run_status  (in_status_ff),
      .pulse_id    (in_pid_ff),
      .count_skips (count_skips_ff),
      .result      (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.phase_error, !rsp_ff.admitted, rsp_ff.admitted};
   assign rsp_tdata  = {6'd0, rsp_ff.skip_total, rsp_ff.pulses_seen, rsp_ff.run_phase};

`ifndef SYNTH
   // an empty input register always takes a header
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("req_tready low with empty input register");

   // a phase error only comes with an admitted run status packet
   a_error_admitted: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> rsp_tuser[0])
      else $error("phase error on a packet that was not admitted");

   // with skip counting off, a decision never moves the skip counter
   a_skip_hold: assert property (@(posedge clock) disable iff (reset)
      (step && !count_skips_ff) |-> (result.skip_total == u_core.skip_cnt_ff))
      else $error("skip counter moved while counting disabled");

   // done is entered only through an end run status
   a_done_entry: assert property (@(posedge clock) disable iff (reset)
      (step && result.run_phase == PHASE_DONE && !result.phase_error && result.admitted
       && pkt_class != CLS_RUN_STATUS) |-> 1'b0)
      else $error("done phase reached by a packet other than run status");
`endif

endmodule
